>>> rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, codes and constants of the cluster chain table engine.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 8192;

    localparam logic [15:0] MEDIA_MARK = 16'hFFF8;
    localparam logic [15:0] END_MARK   = 16'hFFFF;
    localparam logic [15:0] FIRST_DATA = 16'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADARG  = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    typedef enum logic [2:0] {
        K_ALLOC  = 3'd0,
        K_FREE   = 3'd1,
        K_NEXT   = 3'd2,
        K_TERM   = 3'd3,
        K_READ   = 3'd4,
        K_FORMAT = 3'd5,
        K_VERIFY = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_ASCAN, S_EXT, S_VSCAN, S_FR_F, S_FR_W,
        S_NX_W, S_TM_W, S_RD_W, S_FMT, S_DONE
    } t_state;

    typedef enum logic [1:0] {IDX_HOLD, IDX_DATA, IDX_ZERO, IDX_INC} t_idx_op;
    typedef enum logic [1:0] {RA_IDX, RA_ARG, RA_LINK} t_ra_sel;
    typedef enum logic [1:0] {WA_IDX, WA_PIDX, WA_ARG, WA_WALK} t_wa_sel;
    typedef enum logic [1:0] {WD_ZERO, WD_END, WD_INIT, WD_PIDX} t_wd_sel;
    typedef enum logic [3:0] {
        RES_BADARG, RES_ZERO, RES_FOUND, RES_XFOUND, RES_FULL, RES_XFULL,
        RES_VBAD, RES_FIRST, RES_LINK, RES_CORR, RES_RDVAL
    } t_res;

    typedef struct packed {
        logic    in_rdy;
        t_idx_op idx_op;
        t_ra_sel ra_sel;
        logic    walk_ld;
        logic    first_ld;
        logic    wr_en;
        t_wa_sel wa_sel;
        t_wd_sel wd_sel;
        logic    res_ld;
        t_res    res_sel;
        logic    out_ld;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_kind kind;
        logic  arg_data;
        logic  arg_rd;
        logic  rd_zero;
        logic  rd_end;
        logic  rd_link;
        logic  v_bad;
        logic  pv;
        logic  idx_done;
        logic  clr_last;
        logic  out_free;
    } t_sts;

endpackage

>>> rtl/cct_ram.sv
// ----------------------------------------------------------------------------
// cct_ram
// Simple dual-port RAM, one write and one registered read port, write-first.
// ----------------------------------------------------------------------------
module cct_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> rtl/cct_ctrl.sv
// ----------------------------------------------------------------------------
// cct_ctrl
// Operation sequencer: decodes each beat and steps scans, walks and sweeps.
// ----------------------------------------------------------------------------
module cct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cct_pkg::t_sts i_sts,
    output cct_pkg::t_cmd o_cmd
);
    cct_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cct_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cct_pkg::S_INIT: begin
                if (i_sts.clr_last) n_state = cct_pkg::S_IDLE;
            end
            cct_pkg::S_IDLE: begin
                if (i_sts.in_valid) n_state = cct_pkg::S_DISP;
            end
            cct_pkg::S_DISP: begin
                case (i_sts.kind)
                    cct_pkg::K_ALLOC:  n_state = cct_pkg::S_ASCAN;
                    cct_pkg::K_FREE:
                        n_state = i_sts.arg_data ? cct_pkg::S_FR_F : cct_pkg::S_DONE;
                    cct_pkg::K_NEXT:
                        n_state = i_sts.arg_data ? cct_pkg::S_NX_W : cct_pkg::S_DONE;
                    cct_pkg::K_TERM:
                        n_state = i_sts.arg_data ? cct_pkg::S_TM_W : cct_pkg::S_DONE;
                    cct_pkg::K_READ:
                        n_state = i_sts.arg_rd ? cct_pkg::S_RD_W : cct_pkg::S_DONE;
                    cct_pkg::K_FORMAT: n_state = cct_pkg::S_FMT;
                    cct_pkg::K_VERIFY: n_state = cct_pkg::S_VSCAN;
                    default:           n_state = cct_pkg::S_DONE;
                endcase
            end
            cct_pkg::S_ASCAN: begin
                if (i_sts.pv && i_sts.rd_zero) begin
                    n_state = (i_sts.kind == cct_pkg::K_NEXT) ? cct_pkg::S_EXT
                                                              : cct_pkg::S_DONE;
                end else if (!i_sts.pv && i_sts.idx_done) begin
                    n_state = cct_pkg::S_DONE;
                end
            end
            cct_pkg::S_EXT: n_state = cct_pkg::S_DONE;
            cct_pkg::S_VSCAN: begin
                if ((i_sts.pv && i_sts.v_bad) || (!i_sts.pv && i_sts.idx_done)) begin
                    n_state = cct_pkg::S_DONE;
                end
            end
            cct_pkg::S_FR_F, cct_pkg::S_FR_W: begin
                if (!i_sts.rd_zero && !i_sts.rd_end && i_sts.rd_link) begin
                    n_state = cct_pkg::S_FR_W;
                end else begin
                    n_state = cct_pkg::S_DONE;
                end
            end
            cct_pkg::S_NX_W: begin
                n_state = i_sts.rd_end ? cct_pkg::S_ASCAN : cct_pkg::S_DONE;
            end
            cct_pkg::S_TM_W: n_state = cct_pkg::S_DONE;
            cct_pkg::S_RD_W: n_state = cct_pkg::S_DONE;
            cct_pkg::S_FMT: begin
                if (i_sts.clr_last) n_state = cct_pkg::S_DONE;
            end
            cct_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = cct_pkg::S_IDLE;
            end
            default: n_state = cct_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.idx_op   = cct_pkg::IDX_HOLD;
        o_cmd.ra_sel   = cct_pkg::RA_ARG;
        o_cmd.wa_sel   = cct_pkg::WA_IDX;
        o_cmd.wd_sel   = cct_pkg::WD_ZERO;
        o_cmd.res_sel  = cct_pkg::RES_ZERO;
        case (r_state)
            cct_pkg::S_INIT, cct_pkg::S_FMT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = cct_pkg::WA_IDX;
                o_cmd.wd_sel = cct_pkg::WD_INIT;
                o_cmd.idx_op = cct_pkg::IDX_INC;
                if (r_state == cct_pkg::S_FMT && i_sts.clr_last) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cct_pkg::RES_ZERO;
                end
            end
            cct_pkg::S_IDLE: o_cmd.in_rdy = 1'b1;
            cct_pkg::S_DISP: begin
                o_cmd.ra_sel  = cct_pkg::RA_ARG;
                o_cmd.walk_ld = 1'b1;
                o_cmd.res_sel = cct_pkg::RES_BADARG;
                case (i_sts.kind)
                    cct_pkg::K_ALLOC:  o_cmd.idx_op = cct_pkg::IDX_DATA;
                    cct_pkg::K_FREE, cct_pkg::K_NEXT, cct_pkg::K_TERM:
                        o_cmd.res_ld = !i_sts.arg_data;
                    cct_pkg::K_READ:   o_cmd.res_ld = !i_sts.arg_rd;
                    cct_pkg::K_FORMAT: o_cmd.idx_op = cct_pkg::IDX_ZERO;
                    cct_pkg::K_VERIFY: o_cmd.idx_op = cct_pkg::IDX_ZERO;
                    default:           o_cmd.res_ld = 1'b1;
                endcase
            end
            cct_pkg::S_ASCAN: begin
                o_cmd.ra_sel = cct_pkg::RA_IDX;
                o_cmd.idx_op = cct_pkg::IDX_INC;
                if (i_sts.pv && i_sts.rd_zero) begin
                    o_cmd.idx_op = cct_pkg::IDX_HOLD;
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wa_sel = cct_pkg::WA_PIDX;
                    o_cmd.wd_sel = cct_pkg::WD_END;
                    o_cmd.res_ld  = (i_sts.kind != cct_pkg::K_NEXT);
                    o_cmd.res_sel = cct_pkg::RES_FOUND;
                end else if (!i_sts.pv && i_sts.idx_done) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = (i_sts.kind == cct_pkg::K_NEXT) ? cct_pkg::RES_XFULL
                                                                    : cct_pkg::RES_FULL;
                end
            end
            cct_pkg::S_EXT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wa_sel  = cct_pkg::WA_ARG;
                o_cmd.wd_sel  = cct_pkg::WD_PIDX;
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = cct_pkg::RES_XFOUND;
            end
            cct_pkg::S_VSCAN: begin
                o_cmd.ra_sel = cct_pkg::RA_IDX;
                o_cmd.idx_op = cct_pkg::IDX_INC;
                if (i_sts.pv && i_sts.v_bad) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cct_pkg::RES_VBAD;
                end else if (!i_sts.pv && i_sts.idx_done) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cct_pkg::RES_ZERO;
                end
            end
            cct_pkg::S_FR_F, cct_pkg::S_FR_W: begin
                o_cmd.first_ld = (r_state == cct_pkg::S_FR_F);
                o_cmd.res_sel  = cct_pkg::RES_FIRST;
                if (i_sts.rd_zero) begin
                    o_cmd.res_ld = 1'b1;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wa_sel = cct_pkg::WA_WALK;
                    o_cmd.wd_sel = cct_pkg::WD_ZERO;
                    if (!i_sts.rd_end && i_sts.rd_link) begin
                        o_cmd.ra_sel  = cct_pkg::RA_LINK;
                        o_cmd.walk_ld = 1'b1;
                    end else begin
                        o_cmd.res_ld = 1'b1;
                    end
                end
            end
            cct_pkg::S_NX_W: begin
                o_cmd.first_ld = 1'b1;
                if (i_sts.rd_end) begin
                    o_cmd.idx_op = cct_pkg::IDX_DATA;
                end else begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = i_sts.rd_link ? cct_pkg::RES_LINK : cct_pkg::RES_CORR;
                end
            end
            cct_pkg::S_TM_W: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wa_sel  = cct_pkg::WA_ARG;
                o_cmd.wd_sel  = cct_pkg::WD_END;
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = cct_pkg::RES_RDVAL;
            end
            cct_pkg::S_RD_W: begin
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = cct_pkg::RES_RDVAL;
            end
            cct_pkg::S_DONE: o_cmd.out_ld = i_sts.out_free;
            default: ;
        endcase
    end
endmodule

>>> rtl/cct_dp.sv
// ----------------------------------------------------------------------------
// cct_dp
// Datapath: table RAM, scan and walk pointers, result and output registers.
// ----------------------------------------------------------------------------
module cct_dp #(
    parameter int unsigned TABLE_ENTRIES = cct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cct_pkg::t_cmd i_cmd,
    output cct_pkg::t_sts o_sts,
    input  logic          s_axis_tvalid,
    input  logic [15:0]   s_axis_tdata,
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned IW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [16:0] NE = 17'(TABLE_ENTRIES);

    logic [2:0]    r_kind;
    logic [15:0]   r_arg;
    logic [IW-1:0] r_idx;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] r_walk;
    logic [15:0]   r_first;
    logic [1:0]    r_status;
    logic [12:0]   r_cout;
    logic [15:0]   r_val;
    logic          r_ovalid;
    logic [31:0]   r_odata;

    logic [15:0]   rd_data;
    logic [AW-1:0] raddr, waddr;
    logic [15:0]   wdata, init_val, first_val, pidx16;
    logic [1:0]    res_status;
    logic [12:0]   res_cout;
    logic [15:0]   res_val;
    logic          idx_done, rd_zero, rd_end, rd_link;

    assign idx_done  = (r_idx == IW'(TABLE_ENTRIES));
    assign rd_zero   = (rd_data == 16'd0);
    assign rd_end    = (rd_data == cct_pkg::END_MARK);
    assign rd_link   = (rd_data >= cct_pkg::FIRST_DATA) && ({1'b0, rd_data} < NE);
    assign pidx16    = 16'(r_pidx);
    assign first_val = i_cmd.first_ld ? rd_data : r_first;

    always_comb begin
        if (r_idx[AW-1:0] == AW'(0)) begin
            init_val = cct_pkg::MEDIA_MARK;
        end else if (r_idx[AW-1:0] == AW'(1)) begin
            init_val = cct_pkg::END_MARK;
        end else begin
            init_val = 16'd0;
        end
    end

    always_comb begin
        case (i_cmd.ra_sel)
            cct_pkg::RA_IDX:  raddr = r_idx[AW-1:0];
            cct_pkg::RA_LINK: raddr = rd_data[AW-1:0];
            default:          raddr = r_arg[AW-1:0];
        endcase
        case (i_cmd.wa_sel)
            cct_pkg::WA_PIDX: waddr = r_pidx;
            cct_pkg::WA_ARG:  waddr = r_arg[AW-1:0];
            cct_pkg::WA_WALK: waddr = r_walk;
            default:          waddr = r_idx[AW-1:0];
        endcase
        case (i_cmd.wd_sel)
            cct_pkg::WD_END:  wdata = cct_pkg::END_MARK;
            cct_pkg::WD_INIT: wdata = init_val;
            cct_pkg::WD_PIDX: wdata = pidx16;
            default:          wdata = 16'd0;
        endcase
    end

    cct_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        res_status = cct_pkg::ST_OK;
        res_cout   = 13'd0;
        res_val    = 16'd0;
        case (i_cmd.res_sel)
            cct_pkg::RES_BADARG: res_status = cct_pkg::ST_BADARG;
            cct_pkg::RES_FOUND: begin
                res_cout = pidx16[12:0];
                res_val  = cct_pkg::END_MARK;
            end
            cct_pkg::RES_XFOUND: begin
                res_cout = pidx16[12:0];
                res_val  = first_val;
            end
            cct_pkg::RES_FULL:   res_status = cct_pkg::ST_FULL;
            cct_pkg::RES_XFULL: begin
                res_status = cct_pkg::ST_FULL;
                res_val    = first_val;
            end
            cct_pkg::RES_VBAD: begin
                res_status = cct_pkg::ST_CORRUPT;
                res_cout   = pidx16[12:0];
                res_val    = rd_data;
            end
            cct_pkg::RES_FIRST:  res_val = first_val;
            cct_pkg::RES_LINK: begin
                res_cout = rd_data[12:0];
                res_val  = rd_data;
            end
            cct_pkg::RES_CORR: begin
                res_status = cct_pkg::ST_CORRUPT;
                res_val    = rd_data;
            end
            cct_pkg::RES_RDVAL:  res_val = rd_data;
            default: ;
        endcase
    end

    always_comb begin
        o_sts          = '0;
        o_sts.in_valid = s_axis_tvalid;
        o_sts.kind     = cct_pkg::t_kind'(r_kind);
        o_sts.arg_data = (r_arg >= cct_pkg::FIRST_DATA) && ({1'b0, r_arg} < NE);
        o_sts.arg_rd   = ({1'b0, r_arg} < NE);
        o_sts.rd_zero  = rd_zero;
        o_sts.rd_end   = rd_end;
        o_sts.rd_link  = rd_link;
        if (r_pidx == AW'(0)) begin
            o_sts.v_bad = (rd_data != cct_pkg::MEDIA_MARK);
        end else if (r_pidx == AW'(1)) begin
            o_sts.v_bad = !rd_end;
        end else begin
            o_sts.v_bad = !(rd_zero || rd_end || rd_link);
        end
        o_sts.pv       = r_pv;
        o_sts.idx_done = idx_done;
        o_sts.clr_last = (r_idx[AW-1:0] == AW'(TABLE_ENTRIES - 1));
        o_sts.out_free = !r_ovalid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_cmd.idx_op)
                cct_pkg::IDX_DATA: begin
                    r_idx <= IW'(2);
                    r_pv  <= 1'b0;
                end
                cct_pkg::IDX_ZERO: begin
                    r_idx <= '0;
                    r_pv  <= 1'b0;
                end
                cct_pkg::IDX_INC: begin
                    r_pv <= !idx_done;
                    if (!idx_done) r_idx <= r_idx + IW'(1);
                end
                default: r_pv <= 1'b0;
            endcase
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_rdy && s_axis_tvalid) begin
            r_kind <= s_axis_tuser;
            r_arg  <= s_axis_tdata;
        end
        if (i_cmd.idx_op == cct_pkg::IDX_INC) r_pidx <= r_idx[AW-1:0];
        if (i_cmd.walk_ld) r_walk <= raddr;
        if (i_cmd.first_ld) r_first <= rd_data;
        if (i_cmd.res_ld) begin
            r_status <= res_status;
            r_cout   <= res_cout;
            r_val    <= res_val;
        end
        if (i_cmd.out_ld) r_odata <= {1'b0, r_val, r_cout, r_status};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

>>> rtl/cluster_chain_table_engine.sv
// ----------------------------------------------------------------------------
// cluster_chain_table_engine
// Cluster chain allocation table: alloc, free, link, terminate, read, format, check.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser
// s_axis   in   [15:0] cluster                 [2:0] kind
// m_axis   out  [1:0] status, [14:2] cluster_out, [30:15] entry_value, [31] 0
//
// One beat at a time. Read, terminate and next need no scan; bad arguments skip the table.
// Alloc scans one entry per cycle until it finds a free entry; verify scans to a bad one.
// Next with an extension adds the alloc scan.
// Free walks the chain link by link; format sweeps every entry of the table.
// After reset the table is swept with s_axis_tready low.
// A result held by m_axis_tready stalls the next beat's completion only.
// ----------------------------------------------------------------------------
module cluster_chain_table_engine #(
    parameter int unsigned TABLE_ENTRIES = cct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // cluster
    input  logic [2:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status, cluster_out, entry_value, pad
);
    cct_pkg::t_cmd cmd;
    cct_pkg::t_sts sts;

    cct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cct_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_rdy;
endmodule

>>> rtl/cct_chk.sv
// ----------------------------------------------------------------------------
// cct_chk
// Port-level checks of the cluster chain table engine, bound to the top level.
// ----------------------------------------------------------------------------
module cct_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_init_sweep: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("ready during reset sweep");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("beat taken while busy");

    a_full_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == 2'd1) |-> m_axis_tdata[14:2] == 13'd0)
        else $error("full result carries an index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");
endmodule

bind cluster_chain_table_engine cct_chk u_cct_chk (.*);
